// ===== hdl/raa_pkg.sv =====
// Shared types and constants for the rectangle atlas allocator.
// No dependencies; used by every module under hdl/.
package raa_pkg;

    localparam int MAX_FREE_DEF   = 64;
    localparam int COORD_BITS_DEF = 15;
    localparam int FIELD_BITS     = 15;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_NOSP = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic CMD_PACK  = 1'b0;
    localparam logic CMD_RESET = 1'b1;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

endpackage

// ===== hdl/raa_core.sv =====
// Sequencer and free-rectangle memory of the atlas allocator.
// Depends on raa_pkg; fit scan and prune use separate compare logic.
module raa_core
    import raa_pkg::*;
#(
    parameter int MAX_FREE   = MAX_FREE_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  cmd,
    input  logic [FIELD_BITS-1:0] req_w,
    input  logic [FIELD_BITS-1:0] req_h,
    input  logic [FIELD_BITS-1:0] atlas_w,
    input  logic [FIELD_BITS-1:0] atlas_h,
    output logic                  ready,
    output logic                  done,
    output logic [1:0]            status,
    output logic [FIELD_BITS-1:0] pos_x,
    output logic [FIELD_BITS-1:0] pos_y
);

    localparam int IW = $clog2(MAX_FREE);
    localparam int CW = $clog2(MAX_FREE + 1);
    localparam int CB = COORD_BITS;
    localparam int RW = 4 * CB;
    localparam int XW = ((CB > FIELD_BITS) ? CB : FIELD_BITS) + 1;

    typedef enum logic [14:0] {
        S_INIT   = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_RST    = 15'b000000000000100,
        S_SCAN   = 15'b000000000001000,
        S_SCANW  = 15'b000000000010000,
        S_PICK   = 15'b000000000100000,
        S_DPRIME = 15'b000000001000000,
        S_DMOVE  = 15'b000000010000000,
        S_APPR   = 15'b000000100000000,
        S_APPB   = 15'b000001000000000,
        S_PI     = 15'b000010000000000,
        S_PIW    = 15'b000100000000000,
        S_PJ     = 15'b001000000000000,
        S_PCMP   = 15'b010000000000000,
        S_DONE   = 15'b100000000000000
    } state_t;

    // Where the entry delete returns to
    typedef enum logic [1:0] {
        RET_APP = 2'd0,
        RET_J   = 2'd1,
        RET_I   = 2'd2
    } ret_t;

    state_t state_reg, state_next;
    state_t ret_state;

    // Free list memory: one write port, one registered read port
    logic [RW-1:0] mem [MAX_FREE];
    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [RW-1:0] wdata, rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         k_reg, k_next;
    logic [CW-1:0]         i_reg, i_next;
    logic [CW-1:0]         j_reg, j_next;
    logic [CW-1:0]         del_reg, del_next;
    logic [IW-1:0]         best_reg, best_next;
    logic                  found_reg, found_next;
    logic [XW-1:0]         bs_reg, bs_next, bl_reg, bl_next;
    logic [RW-1:0]         ri_reg, ri_next, rb_reg, rb_next;
    ret_t                  ret_reg, ret_next;
    logic [1:0]            status_reg, status_next;
    logic [FIELD_BITS-1:0] px_reg, px_next, py_reg, py_next;
    logic [FIELD_BITS-1:0] w_reg, w_next, h_reg, h_next;

    // Field helpers
    function automatic logic [CB-1:0] fx(input logic [RW-1:0] r);
        return r[CB-1:0];
    endfunction
    function automatic logic [CB-1:0] fy(input logic [RW-1:0] r);
        return r[2*CB-1:CB];
    endfunction
    function automatic logic [CB-1:0] fw(input logic [RW-1:0] r);
        return r[3*CB-1:2*CB];
    endfunction
    function automatic logic [CB-1:0] fh(input logic [RW-1:0] r);
        return r[4*CB-1:3*CB];
    endfunction
    function automatic logic encl(input logic [RW-1:0] o, input logic [RW-1:0] n);
        logic [CB:0] oxe, oye, nxe, nye;
        oxe = {1'b0, fx(o)} + {1'b0, fw(o)};
        oye = {1'b0, fy(o)} + {1'b0, fh(o)};
        nxe = {1'b0, fx(n)} + {1'b0, fw(n)};
        nye = {1'b0, fy(n)} + {1'b0, fh(n)};
        return (fx(n) >= fx(o)) && (fy(n) >= fy(o)) && (nxe <= oxe) && (nye <= oye);
    endfunction

    // Fit metrics of the entry being scanned
    logic [XW-1:0] cw_e, ch_e, rq_w, rq_h, lw, lh, ss, ls;
    logic          fits, better;
    always_comb
    begin
        cw_e = XW'(fw(rdata_reg));
        ch_e = XW'(fh(rdata_reg));
        rq_w = XW'(w_reg);
        rq_h = XW'(h_reg);
        fits = (cw_e >= rq_w) && (ch_e >= rq_h);
        lw   = cw_e - rq_w;
        lh   = ch_e - rq_h;
        ss   = (lw < lh) ? lw : lh;
        ls   = (lw < lh) ? lh : lw;
        better = fits && (!found_reg || ss < bs_reg || (ss == bs_reg && ls < bl_reg));
    end

    // Pieces formed from the chosen rectangle
    logic          pw, ph;
    logic [CW:0]   grow;
    logic [RW-1:0] piece_r, piece_b, full_rect;
    always_comb
    begin
        pw = XW'(fw(rb_reg)) > XW'(w_reg);
        ph = XW'(fh(rb_reg)) > XW'(h_reg);
        grow = {1'b0, count_reg} + (CW + 1)'(pw) + (CW + 1)'(ph) - (CW + 1)'(1);
        piece_r = {CB'(h_reg),
                   CB'(XW'(fw(rb_reg)) - XW'(w_reg)),
                   fy(rb_reg),
                   CB'(XW'(fx(rb_reg)) + XW'(w_reg))};
        piece_b = {CB'(XW'(fh(rb_reg)) - XW'(h_reg)),
                   fw(rb_reg),
                   CB'(XW'(fy(rb_reg)) + XW'(h_reg)),
                   fx(rb_reg)};
        full_rect = {CB'(atlas_h), CB'(atlas_w), {CB{1'b0}}, {CB{1'b0}}};
    end

    // Decode the return point of an entry delete
    always_comb
    begin
        unique case (ret_reg)
            RET_APP: ret_state = S_APPR;
            RET_J:   ret_state = S_PJ;
            RET_I:   ret_state = S_PI;
            default: ret_state = S_PI;
        endcase
    end

    // Sequencer: init, reset, scan, pick, delete, append, prune
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        del_next    = del_reg;
        best_next   = best_reg;
        found_next  = found_reg;
        bs_next     = bs_reg;
        bl_next     = bl_reg;
        ri_next     = ri_reg;
        rb_next     = rb_reg;
        ret_next    = ret_reg;
        status_next = status_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;
        raddr       = '0;
        unique case (state_reg)
            S_INIT:
            begin
                we         = 1'b1;
                wdata      = full_rect;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    w_next      = req_w;
                    h_next      = req_h;
                    status_next = STATUS_OK;
                    px_next     = '0;
                    py_next     = '0;
                    found_next  = 1'b0;
                    k_next      = '0;
                    state_next  = (cmd == CMD_RESET) ? S_RST : S_SCAN;
                end
            end
            S_RST:
            begin
                we         = 1'b1;
                wdata      = full_rect;
                count_next = CW'(1);
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (count_reg == '0)
                begin
                    status_next = STATUS_NOSP;
                    state_next  = S_DONE;
                end
                else
                begin
                    raddr      = '0;
                    state_next = S_SCANW;
                end
            end
            S_SCANW:
            begin
                if (better)
                begin
                    found_next = 1'b1;
                    best_next  = IW'(k_reg);
                    bs_next    = ss;
                    bl_next    = ls;
                    rb_next    = rdata_reg;
                end
                if (k_reg + CW'(1) >= count_reg)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    raddr  = IW'(k_reg + CW'(1));
                    k_next = k_reg + CW'(1);
                end
            end
            S_PICK:
            begin
                if (!found_reg)
                begin
                    status_next = STATUS_NOSP;
                    state_next  = S_DONE;
                end
                else if (grow > (CW + 1)'(MAX_FREE))
                begin
                    status_next = STATUS_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    px_next    = FIELD_BITS'(fx(rb_reg));
                    py_next    = FIELD_BITS'(fy(rb_reg));
                    del_next   = CW'(best_reg);
                    ret_next   = RET_APP;
                    state_next = S_DPRIME;
                end
            end
            S_DPRIME:
            begin
                if (del_reg + CW'(1) >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ret_state;
                end
                else
                begin
                    raddr      = IW'(del_reg + CW'(1));
                    state_next = S_DMOVE;
                end
            end
            S_DMOVE:
            begin
                // Move entry del+1 down into del
                we       = 1'b1;
                waddr    = IW'(del_reg);
                wdata    = rdata_reg;
                del_next = del_reg + CW'(1);
                if (del_reg + CW'(2) >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ret_state;
                end
                else
                begin
                    raddr = IW'(del_reg + CW'(2));
                end
            end
            S_APPR:
            begin
                if (pw)
                begin
                    we         = 1'b1;
                    waddr      = IW'(count_reg);
                    wdata      = piece_r;
                    count_next = count_reg + CW'(1);
                end
                state_next = S_APPB;
            end
            S_APPB:
            begin
                if (ph)
                begin
                    we         = 1'b1;
                    waddr      = IW'(count_reg);
                    wdata      = piece_b;
                    count_next = count_reg + CW'(1);
                end
                i_next     = '0;
                state_next = S_PI;
            end
            S_PI:
            begin
                if (i_reg >= count_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    raddr      = IW'(i_reg);
                    state_next = S_PIW;
                end
            end
            S_PIW:
            begin
                ri_next    = rdata_reg;
                j_next     = i_reg + CW'(1);
                state_next = S_PJ;
            end
            S_PJ:
            begin
                if (j_reg >= count_reg)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_PI;
                end
                else
                begin
                    raddr      = IW'(j_reg);
                    state_next = S_PCMP;
                end
            end
            S_PCMP:
            begin
                // Drop j when i holds it, drop i when j holds it
                if (encl(ri_reg, rdata_reg))
                begin
                    del_next   = j_reg;
                    ret_next   = RET_J;
                    state_next = S_DPRIME;
                end
                else if (encl(rdata_reg, ri_reg))
                begin
                    del_next   = i_reg;
                    ret_next   = RET_I;
                    state_next = S_DPRIME;
                end
                else
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_PJ;
                end
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            count_reg  <= CW'(1);
            k_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            del_reg    <= '0;
            best_reg   <= '0;
            found_reg  <= 1'b0;
            bs_reg     <= '0;
            bl_reg     <= '0;
            ri_reg     <= '0;
            rb_reg     <= '0;
            ret_reg    <= RET_APP;
            status_reg <= STATUS_OK;
            px_reg     <= '0;
            py_reg     <= '0;
            w_reg      <= '0;
            h_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            k_reg      <= k_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            del_reg    <= del_next;
            best_reg   <= best_next;
            found_reg  <= found_next;
            bs_reg     <= bs_next;
            bl_reg     <= bl_next;
            ri_reg     <= ri_next;
            rb_reg     <= rb_next;
            ret_reg    <= ret_next;
            status_reg <= status_next;
            px_reg     <= px_next;
            py_reg     <= py_next;
            w_reg      <= w_next;
            h_reg      <= h_next;
        end
    end

    assign ready  = (state_reg == S_IDLE);
    assign done   = (state_reg == S_DONE);
    assign status = status_reg;
    assign pos_x  = px_reg;
    assign pos_y  = py_reg;

endmodule

// ===== hdl/rect_atlas_allocator.sv =====
// Top level of the rectangle atlas allocator: stream ports, config, output register.
// Depends on raa_pkg and raa_core.
//
//  channel | dir | fields (low bit up)
//  s_axis  | in  | tuser: cmd; tdata: req_width[14:0], req_height[29:15]
//  m_axis  | out | tdata: status[1:0], pos_x[16:2], pos_y[31:17]
//  cfg     | in  | cfg_we, cfg_index, cfg_data
//
// A pack scans the N free entries and picks the best fit, closes the gap of the
// chosen entry, appends up to two pieces, then prunes every pair of entries of
// which one holds the other, closing the gap again for each pruned entry. A reset
// command loads the whole atlas into entry 0 and leaves one free entry.
// After rst_n the init state loads the whole atlas into entry 0 before the input opens.
// The input is not ready while a request is in work or a result waits.
module rect_atlas_allocator
    import raa_pkg::*;
#(
    parameter int MAX_FREE   = MAX_FREE_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // req_width, req_height
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // status, pos_x, pos_y
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [14:0] cfg_data
);

    logic [FIELD_BITS-1:0] atlas_w_reg, atlas_h_reg;
    logic ovalid_reg;
    logic [31:0] odata_reg;
    logic done;
    logic core_ready;
    logic [1:0] st;
    logic [FIELD_BITS-1:0] px, py;
    logic start;

    // Hold atlas size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_w_reg <= 15'd1024;
            atlas_h_reg <= 15'd1024;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_WIDTH)
                atlas_w_reg <= cfg_data;
            else
                atlas_h_reg <= cfg_data;
        end
    end

    assign s_axis_tready = core_ready && !ovalid_reg;
    assign start = s_axis_tvalid && s_axis_tready;

    raa_core #(.MAX_FREE(MAX_FREE), .COORD_BITS(COORD_BITS)) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (s_axis_tuser),
        .req_w   (s_axis_tdata[14:0]),
        .req_h   (s_axis_tdata[29:15]),
        .atlas_w (atlas_w_reg),
        .atlas_h (atlas_h_reg),
        .ready   (core_ready),
        .done    (done),
        .status  (st),
        .pos_x   (px),
        .pos_y   (py)
    );

    // Hold result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            odata_reg  <= '0;
        end
        else
        begin
            if (done)
            begin
                ovalid_reg <= 1'b1;
                odata_reg  <= {py, px, st};
            end
            else if (m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

endmodule
